// File: src/mcpg_pkg.sv
// Package for the multi-channel output pulse generator.
// It holds the opcodes, the command kinds, the field widths and the queue size.
// It has no dependencies; the front, back, top level and checker import it.
package mcpg_pkg;

  // Opcodes carried in the input tuser field.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Fixed field widths of the input and result words.
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned END_W     = 24;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned MAP_W     = 16;

  // Packed input tdata layout, lowest bit first.
  localparam int unsigned IN_DATA_W = 96;
  localparam int unsigned OUT_DATA_W = 2 * MAP_W;

  // Command queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_SET   = 2'd2,
    CMD_START = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [CHAN_W-1:0]     channel;
    logic                  level;
    logic                  direction;
    logic [END_W-1:0]      end1;
    logic [END_W-1:0]      end2;
    logic [END_W-1:0]      end3;
    logic [ELAPSED_W-1:0]  elapsed;
  } cmd_t;

endpackage

// File: src/multi_channel_output_pulse_generator.sv
// Multi-channel output pulse generator, top level. Uses mcpg_pkg, mcpg_front, mcpg_back.
// A set-level or start-pulse word passes through the queue, the execute step and the result
// register; a tick also walks every channel before its result is registered.
// Ticks are paced by the channel walk, which visits one channel per cycle; the back part
// takes a new word only when it is idle and its result slot is free.
// Reset (rst_ni low, asynchronous): all levels, pulse flags, directions, timers cleared.
module multi_channel_output_pulse_generator
  import mcpg_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned TIME_BITS    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input words.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata, lowest bit first: channel[3:0], level[4], direction[5],
  // phase1_end[29:6], phase2_end[53:30], phase3_end[77:54], elapsed[93:78],
  // zero fill[95:94].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op[1:0] (0 tick, 1 set output level, 2 start pulse).
  input  logic [1:0]            s_axis_tuser_i,
  // Result words.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata, lowest bit first: output_levels[15:0], pulse_active[31:16].
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // The front part decodes each word into a command and queues it, so input
  // words are accepted while the back part walks channels, until the queue fills.
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mcpg_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The back part owns all channel state. A tick visits every channel in
  // turn: the phase is chosen from the timer before the tick, then a running
  // channel's timer advances with saturation, an idle one's is cleared. The
  // bitmaps after the word are captured in a register the master side drains.
  mcpg_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

// File: src/mcpg_front.sv
// Front part of the pulse generator: accepts input words, decodes them
// into commands and holds them in a short queue for the back part.
// Depends on mcpg_pkg.
module mcpg_front
  import mcpg_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [IN_DATA_W-1:0] s_tdata_i,
  input  logic [1:0]           s_tuser_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  logic                 cmd_pop_i
);

  cmd_t              cmd_in;
  logic              chan_ok;
  logic              push;
  logic              pop;
  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;

  // Unpack the word and turn out-of-range or unused requests into no-ops.
  always_comb begin
    cmd_in.channel   = s_tdata_i[3:0];
    cmd_in.level     = s_tdata_i[4];
    cmd_in.direction = s_tdata_i[5];
    cmd_in.end1      = s_tdata_i[29:6];
    cmd_in.end2      = s_tdata_i[53:30];
    cmd_in.end3      = s_tdata_i[77:54];
    cmd_in.elapsed   = s_tdata_i[93:78];
    chan_ok = 32'(s_tdata_i[3:0]) < 32'(NUM_CHANNELS);
    unique case (s_tuser_i)
      OP_TICK:  cmd_in.kind = CMD_TICK;
      OP_SET:   cmd_in.kind = chan_ok ? CMD_SET : CMD_NOP;
      OP_START: cmd_in.kind = chan_ok ? CMD_START : CMD_NOP;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  assign s_tready_o  = count_q != QCNT_W'(QUEUE_DEPTH);
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = count_q != '0;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: src/mcpg_back.sv
// Back part of the pulse generator: executes queued commands on the
// per-channel state, walking one channel per cycle on a tick, and holds
// the result word in an output register. Depends on mcpg_pkg.
module mcpg_back
  import mcpg_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned TIME_BITS    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CMP_W = (TIME_BITS > END_W) ? TIME_BITS : END_W;
  localparam int unsigned SUM_W = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;
  localparam int unsigned MAP_N = (NUM_CHANNELS < MAP_W) ? NUM_CHANNELS : MAP_W;
  localparam logic [TIME_BITS-1:0] TIMER_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                 state_q;
  state_e                 state_d;
  logic [IDX_W-1:0]       idx_q;
  logic [ELAPSED_W-1:0]   elapsed_q;
  logic [IDX_W-1:0]       cmd_idx;
  logic                   slot_free;
  logic                   pop;

  logic [NUM_CHANNELS-1:0] level_q;
  logic [NUM_CHANNELS-1:0] running_q;
  logic [NUM_CHANNELS-1:0] dir_q;
  logic [TIME_BITS-1:0]    timer_q [NUM_CHANNELS];
  logic [END_W-1:0]        end1_q  [NUM_CHANNELS];
  logic [END_W-1:0]        end2_q  [NUM_CHANNELS];
  logic [END_W-1:0]        end3_q  [NUM_CHANNELS];

  logic                    res_valid_q;
  logic [OUT_DATA_W-1:0]   res_data_q;

  // Per-channel datapath for the walk.
  logic [CMP_W-1:0]     t_ext;
  logic                 below1;
  logic                 below2;
  logic                 below3;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] sat_sum;

  assign cmd_idx   = IDX_W'(cmd_i.channel);
  assign slot_free = !res_valid_q || m_tready_i;
  assign pop       = (state_q == ST_IDLE) && cmd_valid_i && slot_free;
  assign cmd_pop_o = pop;

  always_comb begin
    t_ext   = CMP_W'(timer_q[idx_q]);
    below1  = t_ext < CMP_W'(end1_q[idx_q]);
    below2  = t_ext < CMP_W'(end2_q[idx_q]);
    below3  = t_ext < CMP_W'(end3_q[idx_q]);
    sum     = SUM_W'(timer_q[idx_q]) + SUM_W'(elapsed_q);
    sat_sum = (sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : sum[TIME_BITS-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          state_d = (cmd_i.kind == CMD_TICK) ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (idx_q == IDX_W'(NUM_CHANNELS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
      level_q     <= '0;
      running_q   <= '0;
      dir_q       <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        timer_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_valid_q && m_tready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (pop) begin
            case (cmd_i.kind)
              CMD_SET: level_q[cmd_idx] <= cmd_i.level;
              CMD_START: begin
                dir_q[cmd_idx]     <= cmd_i.direction;
                timer_q[cmd_idx]   <= '0;
                running_q[cmd_idx] <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          idx_q <= idx_q + IDX_W'(1);
          if (running_q[idx_q]) begin
            if (below1) begin
              level_q[idx_q] <= dir_q[idx_q];
            end else if (below2) begin
              level_q[idx_q] <= ~dir_q[idx_q];
            end else if (below3) begin
              level_q[idx_q] <= dir_q[idx_q];
            end else begin
              running_q[idx_q] <= 1'b0;
            end
            timer_q[idx_q] <= sat_sum;
          end else begin
            timer_q[idx_q] <= '0;
          end
        end
        ST_DONE: res_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers: end times, the tick's elapsed time and the result.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      elapsed_q <= cmd_i.elapsed;
      if (cmd_i.kind == CMD_START) begin
        end1_q[cmd_idx] <= cmd_i.end1;
        end2_q[cmd_idx] <= cmd_i.end2;
        end3_q[cmd_idx] <= cmd_i.end3;
      end
    end
    if (state_q == ST_DONE) begin
      res_data_q <= {MAP_W'(running_q[MAP_N-1:0]), MAP_W'(level_q[MAP_N-1:0])};
    end
  end

  assign m_tvalid_o = res_valid_q;
  assign m_tdata_o  = res_data_q;

endmodule

// File: src/mcpg_checker.sv
// Port-level checker for the pulse generator, bound to the top level.
// Tracks words in flight and checks the result handshake. Depends on mcpg_pkg.
module mcpg_checker
  import mcpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_o,
  input  logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Queue entries plus the one word that the back part holds, either while
  // executing it or in the result register; it takes a new command only
  // once the result register drains.
  localparam int unsigned MAX_PENDING = QUEUE_DEPTH + 1;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pending_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped before acceptance");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != 3'd0)
    else $error("result shown with no word in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'(MAX_PENDING))
    else $error("more words in flight than the block can hold");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'(MAX_PENDING) |-> !s_axis_tready_o)
    else $error("input accepted with every slot occupied");

endmodule

bind multi_channel_output_pulse_generator mcpg_checker u_mcpg_checker (.*);
